// ===== rtl/core/triangle_box_overlap_test_assert.svh =====
// Assertion macros shared by the triangle versus box overlap test RTL.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef TRIANGLE_BOX_OVERLAP_TEST_ASSERT_SVH
`define TRIANGLE_BOX_OVERLAP_TEST_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define TBO_ASSERT_HOLDS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("triangle box overlap assertion failed");

// When the antecedent holds, the consequent holds in the following cycle.
`define TBO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("triangle box overlap assertion failed");

`endif

// ===== rtl/core/tbo_pkg.sv =====
// Package for the triangle versus box overlap test: widths, constants and types.
// Used by tbo_front, tbo_axis_cell and triangle_box_overlap_test; depends on nothing.
`timescale 1ns / 1ps

package tbo_pkg;

	localparam int COORD_FRAC_BITS = 8;
	localparam int COORD_W = 24;
	localparam int HALF_W = 23;
	localparam int NORM_W = COORD_W + 1;
	localparam int MAG_W = COORD_W;
	localparam int PROD_W = NORM_W + COORD_W;
	localparam int SUM_W = PROD_W + 1;
	localparam int HPROD_W = MAG_W + HALF_W;
	localparam int RAD_W = HPROD_W + 1;
	localparam int SQ_W = 2 * MAG_W;
	localparam int NN_W = SQ_W + 1;
	localparam int WIDE_W = SUM_W + 2;
	localparam int EPS_MUL_W = NN_W + 8;
	localparam int EPS_SHIFT = 17;
	localparam int NUM_AXES = 5;
	localparam int NUM_VERTS = 3;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam longint unsigned NN_MIN =
		((64'd1 << (2 * COORD_FRAC_BITS)) + 64'd999) / 64'd1000;

	localparam logic REG_HALF_WIDTH = 1'b0;
	localparam logic REG_HALF_HEIGHT = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [HALF_W-1:0] half_t;
	typedef logic signed [NORM_W-1:0] norm_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	localparam half_t HALF_RESET = HALF_W'(4096);
	localparam norm_t AXIS_UNIT = NORM_W'(1 << COORD_FRAC_BITS);

	typedef struct packed {
		norm_t nx;
		norm_t ny;
	} axis_t;

	typedef struct packed {
		coord_t [NUM_VERTS-1:0] vx;
		coord_t [NUM_VERTS-1:0] vy;
		coord_t cx;
		coord_t cy;
	} geom_t;

	typedef struct packed {
		geom_t geom;
		axis_t [NUM_AXES-1:0] axes;
		logic sep;
	} tok_t;

endpackage

// ===== rtl/core/tbo_front.sv =====
// Input stage of the overlap test: registers the triangle and box center and
// forms the five candidate axes. Depends on tbo_pkg.
`timescale 1ns / 1ps

module tbo_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  tbo_pkg::coord_t v0_x,
	input  tbo_pkg::coord_t v0_y,
	input  tbo_pkg::coord_t v1_x,
	input  tbo_pkg::coord_t v1_y,
	input  tbo_pkg::coord_t v2_x,
	input  tbo_pkg::coord_t v2_y,
	input  tbo_pkg::coord_t center_x,
	input  tbo_pkg::coord_t center_y,
	output tbo_pkg::tok_t  out_tok,
	output logic           out_valid,
	input  logic           out_ready
);
	import tbo_pkg::*;

	tok_t tok_d;
	tok_t tok_s1;
	logic valid_s1;
	logic ready;

	assign ready = !valid_s1 || out_ready;
	assign item_stall = !ready;

	always_comb begin
		tok_d.geom.vx[0] = v0_x;
		tok_d.geom.vx[1] = v1_x;
		tok_d.geom.vx[2] = v2_x;
		tok_d.geom.vy[0] = v0_y;
		tok_d.geom.vy[1] = v1_y;
		tok_d.geom.vy[2] = v2_y;
		tok_d.geom.cx = center_x;
		tok_d.geom.cy = center_y;
		tok_d.axes[0].nx = AXIS_UNIT;
		tok_d.axes[0].ny = '0;
		tok_d.axes[1].nx = '0;
		tok_d.axes[1].ny = AXIS_UNIT;
		tok_d.axes[2].nx = norm_t'(v1_y) - norm_t'(v0_y);
		tok_d.axes[2].ny = norm_t'(v0_x) - norm_t'(v1_x);
		tok_d.axes[3].nx = norm_t'(v2_y) - norm_t'(v1_y);
		tok_d.axes[3].ny = norm_t'(v1_x) - norm_t'(v2_x);
		tok_d.axes[4].nx = norm_t'(v0_y) - norm_t'(v2_y);
		tok_d.axes[4].ny = norm_t'(v2_x) - norm_t'(v0_x);
		tok_d.sep = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && item_valid) begin
			tok_s1 <= tok_d;
		end
	end

	assign out_tok = tok_s1;
	assign out_valid = valid_s1;

endmodule

// ===== rtl/core/tbo_axis_cell.sv =====
// One cell of the axis chain: tests the axis at the head of the token's axis list
// in four pipeline stages and passes the token on. Depends on tbo_pkg and the
// assertion macro header.
`timescale 1ns / 1ps
`include "triangle_box_overlap_test_assert.svh"

module tbo_axis_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  tbo_pkg::half_t half_w,
	input  tbo_pkg::half_t half_h,
	input  tbo_pkg::tok_t in_tok,
	input  logic          in_valid,
	output logic          in_ready,
	output tbo_pkg::tok_t out_tok,
	output logic          out_valid,
	input  logic          out_ready
);
	import tbo_pkg::*;

	typedef struct packed {
		tok_t tok;
		prod_t [NUM_VERTS-1:0] pvx;
		prod_t [NUM_VERTS-1:0] pvy;
		prod_t pcx;
		prod_t pcy;
		logic [HPROD_W-1:0] rx;
		logic [HPROD_W-1:0] ry;
		logic [SQ_W-1:0] sx;
		logic [SQ_W-1:0] sy;
	} prod_stage_t;

	typedef struct packed {
		tok_t tok;
		sum_t [NUM_VERTS-1:0] t;
		sum_t c;
		logic [RAD_W-1:0] r;
		logic [NN_W-1:0] nn;
	} sum_stage_t;

	typedef struct packed {
		tok_t tok;
		wide_t tmin;
		wide_t tmax;
		wide_t bmin;
		wide_t bmax;
		wide_t eps;
		logic skip;
	} range_stage_t;

	prod_stage_t  p_d, p_s1;
	sum_stage_t   s_d, s_s2;
	range_stage_t g_d, g_s3;
	tok_t         t_d, t_s4;
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4 = !v_s4 || out_ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		norm_t nax, nay;
		logic [MAG_W-1:0] mx, my;
		nax = in_tok.axes[0].nx[NORM_W-1] ? -in_tok.axes[0].nx : in_tok.axes[0].nx;
		nay = in_tok.axes[0].ny[NORM_W-1] ? -in_tok.axes[0].ny : in_tok.axes[0].ny;
		mx = nax[MAG_W-1:0];
		my = nay[MAG_W-1:0];
		p_d.tok = in_tok;
		for (int k = 0; k < NUM_VERTS; k++) begin
			p_d.pvx[k] = $signed(in_tok.axes[0].nx) * $signed(in_tok.geom.vx[k]);
			p_d.pvy[k] = $signed(in_tok.axes[0].ny) * $signed(in_tok.geom.vy[k]);
		end
		p_d.pcx = $signed(in_tok.axes[0].nx) * $signed(in_tok.geom.cx);
		p_d.pcy = $signed(in_tok.axes[0].ny) * $signed(in_tok.geom.cy);
		p_d.rx = mx * half_w;
		p_d.ry = my * half_h;
		p_d.sx = mx * mx;
		p_d.sy = my * my;
	end

	always_comb begin
		s_d.tok = p_s1.tok;
		for (int k = 0; k < NUM_VERTS; k++) begin
			s_d.t[k] = sum_t'($signed(p_s1.pvx[k])) + sum_t'($signed(p_s1.pvy[k]));
		end
		s_d.c = sum_t'($signed(p_s1.pcx)) + sum_t'($signed(p_s1.pcy));
		s_d.r = RAD_W'(p_s1.rx) + RAD_W'(p_s1.ry);
		s_d.nn = NN_W'(p_s1.sx) + NN_W'(p_s1.sy);
	end

	always_comb begin
		sum_t t0, t1, t2, lo01, hi01;
		logic [EPS_MUL_W-1:0] e_mul;
		t0 = s_s2.t[0];
		t1 = s_s2.t[1];
		t2 = s_s2.t[2];
		lo01 = (t0 < t1) ? t0 : t1;
		hi01 = (t0 < t1) ? t1 : t0;
		e_mul = EPS_MUL_W'({s_s2.nn, 7'b0}) + EPS_MUL_W'({s_s2.nn, 1'b0})
			+ EPS_MUL_W'(s_s2.nn);
		g_d.tok = s_s2.tok;
		g_d.tmin = wide_t'((lo01 < t2) ? lo01 : t2);
		g_d.tmax = wide_t'((hi01 > t2) ? hi01 : t2);
		g_d.bmin = wide_t'(s_s2.c) - wide_t'(s_s2.r);
		g_d.bmax = wide_t'(s_s2.c) + wide_t'(s_s2.r);
		g_d.eps = wide_t'(e_mul[EPS_MUL_W-1:EPS_SHIFT]);
		g_d.skip = s_s2.nn < NN_W'(NN_MIN);
	end

	always_comb begin
		wide_t bmin_e, bmax_e, tmin_e, tmax_e;
		logic axis_sep;
		bmin_e = g_s3.bmin + g_s3.eps;
		bmax_e = g_s3.bmax - g_s3.eps;
		tmin_e = g_s3.tmin + g_s3.eps;
		tmax_e = g_s3.tmax - g_s3.eps;
		priority if (g_s3.tmax < bmin_e) begin
			axis_sep = tmin_e < g_s3.bmin;
		end else if (g_s3.tmin > bmax_e) begin
			axis_sep = tmax_e > g_s3.bmax;
		end else begin
			axis_sep = 1'b0;
		end
		t_d.geom = g_s3.tok.geom;
		for (int a = 0; a < NUM_AXES - 1; a++) begin
			t_d.axes[a] = g_s3.tok.axes[a + 1];
		end
		t_d.axes[NUM_AXES-1] = '0;
		t_d.sep = g_s3.tok.sep || (!g_s3.skip && axis_sep);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) p_s1 <= p_d;
		if (rdy2 && v_s1) s_s2 <= s_d;
		if (rdy3 && v_s2) g_s3 <= g_d;
		if (rdy4 && v_s3) t_s4 <= t_d;
	end

	assign out_tok = t_s4;
	assign out_valid = v_s4;

	`TBO_ASSERT_HOLDS(a_tri_range_ordered, !v_s3 || (g_s3.tmin <= g_s3.tmax))
	`TBO_ASSERT_HOLDS(a_box_range_ordered, !v_s3 || (g_s3.bmin <= g_s3.bmax))
	`TBO_ASSERT_NEXT(a_sep_sticky, v_s3 && rdy4 && g_s3.tok.sep, t_s4.sep)
	`TBO_ASSERT_NEXT(a_skip_no_sep, v_s3 && rdy4 && g_s3.skip && !g_s3.tok.sep, !t_s4.sep)

endmodule

// ===== rtl/core/triangle_box_overlap_test.sv =====
// Top level of the 2D triangle versus axis-aligned box overlap test.
// Holds the APB configuration registers and the chain of axis cells.
// Depends on tbo_pkg, tbo_front and tbo_axis_cell.
//
// Usage: a triangle (v0..v2) and a box center arrive on the item channel as one
// transaction; the box half extents come from two APB registers (half_width at
// byte address 0, half_height at 4); the user must write them only while the block
// is idle, as the block itself does not enforce it. One result transaction
// (overlaps) leaves on the result channel per item, in order. Each item passes one
// input stage that forms the five axes, then five axis cells of four stages each.
// The block takes one item per cycle unless stalled; every stage holds a different item.
// Reset clears all valid flags and sets both half extents to 4096.
// When the receiver raises result_stall, the last stage holds its result and the
// chain fills its bubbles stage by stage; item_stall rises only once the input
// stage is full and cannot move on.
`timescale 1ns / 1ps

module triangle_box_overlap_test (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tbo_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [tbo_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [tbo_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  tbo_pkg::coord_t                    v0_x,
	input  tbo_pkg::coord_t                    v0_y,
	input  tbo_pkg::coord_t                    v1_x,
	input  tbo_pkg::coord_t                    v1_y,
	input  tbo_pkg::coord_t                    v2_x,
	input  tbo_pkg::coord_t                    v2_y,
	input  tbo_pkg::coord_t                    center_x,
	input  tbo_pkg::coord_t                    center_y,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               overlaps
);
	import tbo_pkg::*;

	half_t half_width_q;
	half_t half_height_q;
	logic  cfg_write;
	logic  reg_sel;

	tok_t chain_tok [NUM_AXES+1];
	logic chain_valid [NUM_AXES+1];
	logic chain_ready [NUM_AXES+1];

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= HALF_RESET;
			half_height_q <= HALF_RESET;
		end else if (cfg_write) begin
			unique case (reg_sel)
				REG_HALF_WIDTH: half_width_q <= pwdata[HALF_W-1:0];
				REG_HALF_HEIGHT: half_height_q <= pwdata[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_HALF_WIDTH: prdata = APB_DATA_W'(half_width_q);
			REG_HALF_HEIGHT: prdata = APB_DATA_W'(half_height_q);
			default: prdata = '0;
		endcase
	end

	tbo_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.v0_x       (v0_x),
		.v0_y       (v0_y),
		.v1_x       (v1_x),
		.v1_y       (v1_y),
		.v2_x       (v2_x),
		.v2_y       (v2_y),
		.center_x   (center_x),
		.center_y   (center_y),
		.out_tok    (chain_tok[0]),
		.out_valid  (chain_valid[0]),
		.out_ready  (chain_ready[0])
	);

	for (genvar g = 0; g < NUM_AXES; g++) begin : g_cell
		tbo_axis_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.half_w    (half_width_q),
			.half_h    (half_height_q),
			.in_tok    (chain_tok[g]),
			.in_valid  (chain_valid[g]),
			.in_ready  (chain_ready[g]),
			.out_tok   (chain_tok[g+1]),
			.out_valid (chain_valid[g+1]),
			.out_ready (chain_ready[g+1])
		);
	end

	assign chain_ready[NUM_AXES] = !result_stall;
	assign result_valid = chain_valid[NUM_AXES];
	assign overlaps = !chain_tok[NUM_AXES].sep;

endmodule
